// File: rtl/lbbd_pkg.sv
// Package for the LED blink and button debounce block.
// Holds field widths, register map, mode codes and shared structs.
// Used by lbbd_core and led_blink_and_button_debounce_top.
`timescale 1ns / 1ps

package lbbd_pkg;

  localparam int LED_COUNT    = 8;
  localparam int BUTTON_COUNT = 16;
  localparam int TIME_WIDTH   = 32;
  localparam int LED_IDX_W    = 3;
  localparam int COUNT_W      = 8;
  localparam int APB_ADDR_W   = 4;
  localparam int APB_DATA_W   = 32;

  localparam logic [TIME_WIDTH-1:0] SLOW_PERIOD_RESET = TIME_WIDTH'(500);
  localparam logic [TIME_WIDTH-1:0] FAST_PERIOD_RESET = TIME_WIDTH'(100);
  localparam logic [COUNT_W-1:0]    DEBOUNCE_RESET    = COUNT_W'(3);

  typedef enum logic [1:0] {
    REG_SLOW_PERIOD    = 2'd0,
    REG_FAST_PERIOD    = 2'd1,
    REG_DEBOUNCE_COUNT = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SLOW = 2'd2,
    MODE_FAST = 2'd3
  } led_mode_t;

  typedef enum logic {
    CMD_SET_LED = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] slow_period;
    logic [TIME_WIDTH-1:0] fast_period;
    logic [COUNT_W-1:0]    debounce_count;
  } cfg_t;

  typedef struct packed {
    logic [LED_COUNT-1:0]    led_mask;
    logic [BUTTON_COUNT-1:0] buttons_stable;
  } result_t;

endpackage

// File: rtl/led_blink_and_button_debounce_top.sv
// Top level of the LED blink and button debounce block: APB registers,
// input handshake and a two-entry result queue. Depends on lbbd_pkg, lbbd_core.
//
//   channel   direction  handshake          payload
//   input     in         in_valid/in_stall  cmd, led_index, led_mode, now_time, buttons_raw
//   result    out        out_valid/out_stall led_mask, buttons_stable
//   config    in         APB psel/penable   paddr, pwdata, prdata
//
// The state update for each word is one subtract and compare per blink
// phase, and a word is taken on every cycle that in_stall is low.
// A result is registered in the output register, or in the skid entry if that is full.
// A skid entry behind the output register lets one more word in while a
// result is stalled; in_stall rises only when both entries are full.
// Synchronous reset clears core state, sets register reset values and empties the queue.
`timescale 1ns / 1ps

module led_blink_and_button_debounce_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lbbd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lbbd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lbbd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [lbbd_pkg::LED_IDX_W-1:0]      led_index,
  input  logic [1:0]                          led_mode,
  input  logic [lbbd_pkg::TIME_WIDTH-1:0]     now_time,
  input  logic [lbbd_pkg::BUTTON_COUNT-1:0]   buttons_raw,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lbbd_pkg::LED_COUNT-1:0]      led_mask,
  output logic [lbbd_pkg::BUTTON_COUNT-1:0]   buttons_stable
);
  import lbbd_pkg::*;

  cfg_t       cfg;
  reg_index_t reg_sel;
  logic       cfg_write;
  logic       accept;
  logic       pop;
  result_t    new_result;
  result_t    out_word, skid_word;
  logic       skid_valid;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_period    <= SLOW_PERIOD_RESET;
      cfg.fast_period    <= FAST_PERIOD_RESET;
      cfg.debounce_count <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SLOW_PERIOD:    cfg.slow_period    <= pwdata[TIME_WIDTH-1:0];
        REG_FAST_PERIOD:    cfg.fast_period    <= pwdata[TIME_WIDTH-1:0];
        REG_DEBOUNCE_COUNT: cfg.debounce_count <= pwdata[COUNT_W-1:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SLOW_PERIOD:    prdata = APB_DATA_W'(cfg.slow_period);
      REG_FAST_PERIOD:    prdata = APB_DATA_W'(cfg.fast_period);
      REG_DEBOUNCE_COUNT: prdata = APB_DATA_W'(cfg.debounce_count);
      default:            prdata = '0;
    endcase
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign pop      = out_valid && !out_stall;

  lbbd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cfg         (cfg),
    .cmd         (cmd),
    .led_index   (led_index),
    .led_mode    (led_mode),
    .now_time    (now_time),
    .buttons_raw (buttons_raw),
    .result      (new_result)
  );

  // Two-entry result queue: the output register first, the skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        out_word  <= new_result;
      end
    end else if (accept) begin
      if (!out_valid) begin
        out_word  <= new_result;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= new_result;
        skid_valid <= 1'b1;
      end
    end
  end

  assign led_mask       = out_word.led_mask;
  assign buttons_stable = out_word.buttons_stable;

endmodule

// File: rtl/lbbd_core.sv
// State and per-word logic of the LED blink and button debounce block.
// Depends on lbbd_pkg; instantiated by led_blink_and_button_debounce_top.
`timescale 1ns / 1ps

module lbbd_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  lbbd_pkg::cfg_t                    cfg,
  input  logic                              cmd,
  input  logic [lbbd_pkg::LED_IDX_W-1:0]    led_index,
  input  logic [1:0]                        led_mode,
  input  logic [lbbd_pkg::TIME_WIDTH-1:0]   now_time,
  input  logic [lbbd_pkg::BUTTON_COUNT-1:0] buttons_raw,
  output lbbd_pkg::result_t                 result
);
  import lbbd_pkg::*;

  logic [LED_COUNT-1:0]    steady_on, slow_set, fast_set;
  logic [LED_COUNT-1:0]    steady_on_next, slow_set_next, fast_set_next;
  logic                    slow_phase, fast_phase, slow_phase_next, fast_phase_next;
  logic [TIME_WIDTH-1:0]   slow_stamp, fast_stamp, slow_stamp_next, fast_stamp_next;
  logic [LED_COUNT-1:0]    shown_mask, shown_mask_next;
  logic [BUTTON_COUNT-1:0] prev_buttons, prev_buttons_next;
  logic [COUNT_W-1:0]      steady_count, steady_count_next;
  logic [BUTTON_COUNT-1:0] settled_buttons, settled_buttons_next;

  logic [TIME_WIDTH-1:0]   slow_elapsed, fast_elapsed;
  logic                    slow_toggle, fast_toggle;
  logic [LED_COUNT-1:0]    led_bit;

  always_comb begin
    steady_on_next       = steady_on;
    slow_set_next        = slow_set;
    fast_set_next        = fast_set;
    slow_phase_next      = slow_phase;
    fast_phase_next      = fast_phase;
    slow_stamp_next      = slow_stamp;
    fast_stamp_next      = fast_stamp;
    shown_mask_next      = shown_mask;
    prev_buttons_next    = prev_buttons;
    steady_count_next    = steady_count;
    settled_buttons_next = settled_buttons;

    led_bit      = LED_COUNT'(1) << led_index;
    // The subtraction wraps, so the elapsed time is correct across a timer rollover.
    slow_elapsed = now_time - slow_stamp;
    fast_elapsed = now_time - fast_stamp;
    slow_toggle  = (|slow_set) && (slow_elapsed >= cfg.slow_period);
    fast_toggle  = (|fast_set) && (fast_elapsed >= cfg.fast_period);

    if (cmd == CMD_SET_LED) begin
      steady_on_next = steady_on & ~led_bit;
      slow_set_next  = slow_set & ~led_bit;
      fast_set_next  = fast_set & ~led_bit;
      case (led_mode_t'(led_mode))
        MODE_ON:   steady_on_next = steady_on_next | led_bit;
        MODE_SLOW: slow_set_next  = slow_set_next | led_bit;
        MODE_FAST: fast_set_next  = fast_set_next | led_bit;
        default:   ;
      endcase
    end else begin
      if (slow_toggle) begin
        slow_stamp_next = now_time;
        slow_phase_next = ~slow_phase;
      end
      if (fast_toggle) begin
        fast_stamp_next = now_time;
        fast_phase_next = ~fast_phase;
      end
      shown_mask_next = steady_on | (slow_phase_next ? slow_set : '0)
                                  | (fast_phase_next ? fast_set : '0);

      if (prev_buttons == buttons_raw) begin
        if (steady_count < cfg.debounce_count) begin
          steady_count_next = steady_count + COUNT_W'(1);
        end
      end else begin
        steady_count_next = '0;
      end
      if (steady_count_next >= cfg.debounce_count) begin
        settled_buttons_next = buttons_raw;
      end
      prev_buttons_next = buttons_raw;
    end

    result.led_mask       = shown_mask_next;
    result.buttons_stable = settled_buttons_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steady_on       <= '0;
      slow_set        <= '0;
      fast_set        <= '0;
      slow_phase      <= 1'b0;
      fast_phase      <= 1'b0;
      slow_stamp      <= '0;
      fast_stamp      <= '0;
      shown_mask      <= '0;
      prev_buttons    <= '0;
      steady_count    <= '0;
      settled_buttons <= '0;
    end else if (accept) begin
      steady_on       <= steady_on_next;
      slow_set        <= slow_set_next;
      fast_set        <= fast_set_next;
      slow_phase      <= slow_phase_next;
      fast_phase      <= fast_phase_next;
      slow_stamp      <= slow_stamp_next;
      fast_stamp      <= fast_stamp_next;
      shown_mask      <= shown_mask_next;
      prev_buttons    <= prev_buttons_next;
      steady_count    <= steady_count_next;
      settled_buttons <= settled_buttons_next;
    end
  end

endmodule

// File: tb/sv/led_blink_and_button_debounce_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_blink_and_button_debounce_top: random and directed words,
// a scoreboard class that predicts every result word, and APB register writes with read-back.
// Depends on lbbd_pkg and the RTL of the block only.

module led_blink_and_button_debounce_top_tb;
  import lbbd_pkg::*;

  class panel_scoreboard;
    logic [TIME_WIDTH-1:0]   slow_per;
    logic [TIME_WIDTH-1:0]   fast_per;
    logic [COUNT_W-1:0]      settle_ticks;
    logic [LED_COUNT-1:0]    on_leds;
    logic [LED_COUNT-1:0]    slow_leds;
    logic [LED_COUNT-1:0]    fast_leds;
    logic [LED_COUNT-1:0]    lit_leds;
    logic                    slow_lit;
    logic                    fast_lit;
    logic [TIME_WIDTH-1:0]   slow_mark;
    logic [TIME_WIDTH-1:0]   fast_mark;
    logic [BUTTON_COUNT-1:0] last_raw;
    logic [BUTTON_COUNT-1:0] debounced;
    logic [COUNT_W-1:0]      unchanged;
    result_t                 panel_q[$];
    int unsigned             faults;
    int unsigned             words;
    int unsigned             ticks;
    int unsigned             checked;

    function new();
      slow_per     = SLOW_PERIOD_RESET;
      fast_per     = FAST_PERIOD_RESET;
      settle_ticks = DEBOUNCE_RESET;
      on_leds      = '0;
      slow_leds    = '0;
      fast_leds    = '0;
      lit_leds     = '0;
      slow_lit     = 1'b0;
      fast_lit     = 1'b0;
      slow_mark    = '0;
      fast_mark    = '0;
      last_raw     = '0;
      debounced    = '0;
      unchanged    = '0;
      faults       = 0;
      words        = 0;
      ticks        = 0;
      checked      = 0;
    endfunction

    function void set_reg(reg_index_t r, logic [APB_DATA_W-1:0] v);
      case (r)
        REG_SLOW_PERIOD:    slow_per = v;
        REG_FAST_PERIOD:    fast_per = v;
        REG_DEBOUNCE_COUNT: settle_ticks = v[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [APB_DATA_W-1:0] reg_value(reg_index_t r);
      case (r)
        REG_SLOW_PERIOD:    return slow_per;
        REG_FAST_PERIOD:    return fast_per;
        REG_DEBOUNCE_COUNT: return APB_DATA_W'(settle_ticks);
        default:            return '0;
      endcase
    endfunction

    // The subtraction wraps at the timestamp width, so a stamp taken just
    // before the wrap still gives the true elapsed time.
    function void blink_step(logic [LED_COUNT-1:0] leds, logic [TIME_WIDTH-1:0] now,
                             logic [TIME_WIDTH-1:0] period,
                             inout logic [TIME_WIDTH-1:0] mark, inout logic lit);
      logic [TIME_WIDTH-1:0] elapsed;
      elapsed = now - mark;
      if (leds != '0 && elapsed >= period) begin
        mark = now;
        lit  = ~lit;
      end
    endfunction

    function void take_word(cmd_t c, logic [LED_IDX_W-1:0] idx, led_mode_t m,
                            logic [TIME_WIDTH-1:0] now, logic [BUTTON_COUNT-1:0] raw);
      logic [LED_COUNT-1:0] sel;
      result_t              due;
      words++;
      if (c == CMD_SET_LED) begin
        if (idx < LED_COUNT) begin
          sel = LED_COUNT'(1) << idx;
          on_leds   &= ~sel;
          slow_leds &= ~sel;
          fast_leds &= ~sel;
          case (m)
            MODE_ON:   on_leds   |= sel;
            MODE_SLOW: slow_leds |= sel;
            MODE_FAST: fast_leds |= sel;
            default: ;
          endcase
        end
      end else begin
        ticks++;
        blink_step(slow_leds, now, slow_per, slow_mark, slow_lit);
        blink_step(fast_leds, now, fast_per, fast_mark, fast_lit);
        lit_leds = on_leds | (slow_lit ? slow_leds : '0) | (fast_lit ? fast_leds : '0);
        // The counter saturates at the register; a counter left above a
        // lowered register stays put and still counts as settled.
        if (last_raw == raw) begin
          if (unchanged < settle_ticks) unchanged++;
        end else begin
          unchanged = '0;
        end
        if (unchanged >= settle_ticks) debounced = raw;
        last_raw = raw;
      end
      due.led_mask       = lit_leds;
      due.buttons_stable = debounced;
      panel_q.push_back(due);
    endfunction

    function void check_output(logic [LED_COUNT-1:0] mask, logic [BUTTON_COUNT-1:0] btn);
      result_t due;
      if (panel_q.size() == 0) begin
        $display("%0t: result word with no prediction waiting: led_mask %h buttons_stable %h",
                 $time, mask, btn);
        faults++;
        return;
      end
      due = panel_q.pop_front();
      checked++;
      if (mask !== due.led_mask) begin
        $display("%0t: led_mask expected %h actual %h", $time, due.led_mask, mask);
        faults++;
      end
      if (btn !== due.buttons_stable) begin
        $display("%0t: buttons_stable expected %h actual %h", $time, due.buttons_stable, btn);
        faults++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_ADDR_W-1:0]   paddr;
  logic [APB_DATA_W-1:0]   pwdata;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    in_valid;
  logic                    in_stall;
  logic                    cmd;
  logic [LED_IDX_W-1:0]    led_index;
  logic [1:0]              led_mode;
  logic [TIME_WIDTH-1:0]   now_time;
  logic [BUTTON_COUNT-1:0] buttons_raw;
  logic                    out_valid;
  logic                    out_stall;
  logic [LED_COUNT-1:0]    led_mask;
  logic [BUTTON_COUNT-1:0] buttons_stable;

  panel_scoreboard         sb = new();
  bit                      quiet;
  logic [TIME_WIDTH-1:0]   clock_now;
  logic [BUTTON_COUNT-1:0] held_raw;

  led_blink_and_button_debounce_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .led_index(led_index),
    .led_mode(led_mode), .now_time(now_time), .buttons_raw(buttons_raw),
    .out_valid(out_valid), .out_stall(out_stall),
    .led_mask(led_mask), .buttons_stable(buttons_stable)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 19);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_output(led_mask, buttons_stable);
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(cmd_t c, logic [LED_IDX_W-1:0] idx, led_mode_t m,
                           logic [TIME_WIDTH-1:0] now, logic [BUTTON_COUNT-1:0] raw);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    led_index   <= idx;
    led_mode    <= m;
    now_time    <= now;
    buttons_raw <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_word(c, idx, m, now, raw);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.panel_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(reg_index_t r, logic [APB_DATA_W-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_ADDR_W'(r) << 2;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(r, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_check(reg_index_t r);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= APB_ADDR_W'(r) << 2;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== sb.reg_value(r)) begin
      $display("%0t: register %s read expected %h actual %h",
               $time, r.name(), sb.reg_value(r), prdata);
      sb.faults++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [TIME_WIDTH-1:0] slow, logic [TIME_WIDTH-1:0] fast,
                           logic [COUNT_W-1:0] settle);
    drain();
    reg_write(REG_SLOW_PERIOD, slow);
    reg_write(REG_FAST_PERIOD, fast);
    reg_write(REG_DEBOUNCE_COUNT, APB_DATA_W'(settle));
    reg_check(REG_SLOW_PERIOD);
    reg_check(REG_FAST_PERIOD);
    reg_check(REG_DEBOUNCE_COUNT);
  endtask

  task automatic tick(logic [TIME_WIDTH-1:0] now, logic [BUTTON_COUNT-1:0] raw);
    clock_now = now;
    send_word(CMD_TICK, LED_IDX_W'($urandom_range(7)), led_mode_t'($urandom_range(3)), now, raw);
  endtask

  // Mostly small forward steps in time with buttons that tend to hold, so
  // that blink phases toggle and the debounce settles; now and then a jump,
  // a step back by one, or a time near the wrap.
  task automatic run_random(int unsigned n, int unsigned step_max, int unsigned hold_pct);
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_word(CMD_SET_LED, LED_IDX_W'($urandom_range(7)), led_mode_t'($urandom_range(3)),
                  $urandom, BUTTON_COUNT'($urandom_range(16'hFFFF)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 80)      clock_now = clock_now + $urandom_range(step_max);
        else if (pick < 88) clock_now = $urandom;
        else if (pick < 94) clock_now = clock_now - 1;
        else                clock_now = 32'hFFFF_FFFF - $urandom_range(step_max);
        if ($urandom_range(99) >= hold_pct) begin
          if ($urandom_range(3) == 0)
            held_raw = held_raw ^ (BUTTON_COUNT'(1) << $urandom_range(BUTTON_COUNT - 1));
          else
            held_raw = BUTTON_COUNT'($urandom_range(16'hFFFF));
        end
        tick(clock_now, held_raw);
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    cmd         = CMD_SET_LED;
    led_index   = '0;
    led_mode    = MODE_OFF;
    now_time    = '0;
    buttons_raw = '0;
    out_stall   = 1'b0;
    quiet       = 1'b0;
    clock_now   = '0;
    held_raw    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words under the reset register values.
    tick(32'd0, 16'hFFFF);
    tick(32'd1, 16'hFFFF);
    tick(32'd2, 16'hFFFF);
    tick(32'd3, 16'hFFFF);
    tick(32'd4, 16'hFFFF);
    send_word(CMD_SET_LED, 3'd0, MODE_ON, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(CMD_SET_LED, 3'd7, MODE_SLOW, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(CMD_SET_LED, 3'd3, MODE_FAST, 32'h0, 16'h0);
    send_word(CMD_SET_LED, 3'd5, MODE_ON, 32'h5555_AAAA, 16'hAAAA);
    send_word(CMD_SET_LED, 3'd5, MODE_OFF, 32'hAAAA_5555, 16'h5555);
    tick(32'd100, 16'hFFFF);
    tick(32'd500, 16'h0000);
    send_word(CMD_SET_LED, 3'd3, MODE_SLOW, 32'h0, 16'h0);
    tick(32'hFFFF_FFFF, 16'h0000);
    tick(32'h0000_0010, 16'h0000);
    tick(32'hFFFF_FF00, 16'hA5A5);
    tick(32'h0000_0200, 16'hA5A5);
    send_word(CMD_SET_LED, 3'd7, MODE_OFF, 32'h0, 16'h0);
    send_word(CMD_SET_LED, 3'd0, MODE_FAST, 32'h0, 16'h0);
    tick(32'h0000_0250, 16'h5A5A);
    tick(32'h0000_0300, 16'h5A5A);
    tick(32'h0000_0350, 16'h5A5A);
    tick(32'h0000_0400, 16'h5A5A);
    tick(32'h0000_0000, 16'h0000);

    // Periods of 1 and no debounce at all.
    configure(32'd1, 32'd1, 8'd0);
    run_random(120, 3, 60);
    // Longest periods and the longest debounce; buttons hold almost always.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
    run_random(280, 50, 99);
    configure(32'd40, 32'd9, 8'd10);
    run_random(200, 8, 92);
    // Debounce lowered below a counter that may already stand high.
    configure($urandom_range(1, 60), $urandom_range(1, 20), 8'd2);
    run_random(120, 10, 80);
    // A long stretch with neither side idling.
    quiet = 1'b1;
    configure(32'd3, 32'd2, 8'd1);
    run_random(130, 3, 70);
    quiet = 1'b0;

    drain();
    repeat (5) @(posedge clk);
    $display("Run covered %0d input words (%0d ticks) over six register settings,",
             sb.words, sb.ticks);
    $display("with %0d result words checked and register read-back after each setting.",
             sb.checked);
    if (sb.faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d result words still awaited.", sb.panel_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
